>>> hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared types and constants for the converter's front, queue and back.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned SatNumW   = 16;  // d*255 fits in 16 bits
  localparam int unsigned HueNumW   = 19;  // (6*d)*255 fits in 19 bits
  localparam int unsigned HueDivW   = 11;  // 6*d fits in 11 bits
  localparam int unsigned QuotW     = 8;
  localparam int unsigned QueueDepthDefault = 2;

  // One classified pixel, ready for the two divisions.
  typedef struct packed {
    logic [SatNumW-1:0] num_s;
    logic [ChanW-1:0]   div_s;
    logic [HueNumW-1:0] num_h;
    logic [HueDivW-1:0] div_h;
    logic [ChanW-1:0]   val;
    logic               zero_hue;
    logic               black;
  } rhc_item_t;

endpackage

>>> hdl/rhc_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter front
// Accepts a pixel, sorts the channels into a sextant and forms the
// numerators and divisors of saturation and hue.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output logic                      q_valid,
  input  logic                      q_stall,
  output rhc_pkg::rhc_item_t        q_item
);
  import rhc_pkg::*;

  logic [ChanW-1:0]   mx, mn, n, d;
  logic [2:0]         k;
  logic               plus;
  logic [HueDivW-1:0] kd, num;
  rhc_item_t          item_next;
  logic               load;

  always_comb begin
    if (green > blue) begin
      if (red > green) begin
        mx = red;   mn = blue; k = 3'd1; plus = 1'b0; n = red - green;
      end else if (blue > red) begin
        mx = green; mn = red;  k = 3'd3; plus = 1'b0; n = green - blue;
      end else begin
        mx = green; mn = blue; k = 3'd1; plus = 1'b1; n = green - red;
      end
    end else begin
      if (red > blue) begin
        mx = red;  mn = green; k = 3'd5; plus = 1'b1; n = red - blue;
      end else if (green > red) begin
        mx = blue; mn = red;   k = 3'd3; plus = 1'b1; n = blue - green;
      end else begin
        mx = blue; mn = green; k = 3'd5; plus = 1'b0; n = blue - red;
      end
    end
    d = mx - mn;
    unique case (k)
      3'd3:    kd = HueDivW'(d) + (HueDivW'(d) << 1);
      3'd5:    kd = HueDivW'(d) + (HueDivW'(d) << 2);
      default: kd = HueDivW'(d);
    endcase
    num = plus ? (kd + HueDivW'(n)) : (kd - HueDivW'(n));
    item_next.num_s    = (SatNumW'(d) << 8) - SatNumW'(d);
    item_next.div_s    = mx;
    item_next.num_h    = (HueNumW'(num) << 8) - HueNumW'(num);
    item_next.div_h    = (HueDivW'(d) << 2) + (HueDivW'(d) << 1);
    item_next.val      = mx;
    item_next.zero_hue = (d == '0);
    item_next.black    = (mx == '0);
  end

  assign in_stall = q_valid && q_stall;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (load) begin
      q_item <= item_next;
    end
  end

endmodule

>>> hdl/rhc_queue.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter queue
// A short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rhc_queue #(
  parameter int unsigned Depth = rhc_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  rhc_pkg::rhc_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_stall,
  output rhc_pkg::rhc_item_t rd_item
);
  import rhc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rhc_item_t       mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign wr_stall = (count == CntW'(Depth));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

>>> hdl/rhc_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter back
// Eight-stage restoring divider pipeline that works out saturation and
// hue side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_stall,
  input  rhc_pkg::rhc_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         hue,
  output logic [7:0]         saturation,
  output logic [7:0]         intensity_value
);
  import rhc_pkg::*;

  typedef struct packed {
    rhc_item_t        it;
    logic [QuotW-1:0] q_s;
    logic [QuotW-1:0] q_h;
  } stage_t;

  function automatic stage_t div_step(input stage_t s, input logic [2:0] sh);
    logic [SatNumW-1:0] ds;
    logic [HueNumW-1:0] dh;
    stage_t             r;
    ds = SatNumW'(s.it.div_s) << sh;
    dh = HueNumW'(s.it.div_h) << sh;
    r  = s;
    if (s.it.num_s >= ds) begin
      r.it.num_s = s.it.num_s - ds;
      r.q_s[sh]  = 1'b1;
    end
    if (s.it.num_h >= dh) begin
      r.it.num_h = s.it.num_h - dh;
      r.q_h[sh]  = 1'b1;
    end
    return r;
  endfunction

  stage_t st      [QuotW];
  stage_t st_next [QuotW];
  logic   v       [QuotW];
  logic   adv     [QuotW];
  stage_t first;

  always_comb begin
    first.it  = q_item;
    first.q_s = '0;
    first.q_h = '0;
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    if (s == QuotW - 1) begin : g_last
      assign adv[s] = !v[s] || !out_stall;
    end else begin : g_mid
      assign adv[s] = !v[s] || adv[s+1];
    end
    if (s == 0) begin : g_head
      assign st_next[s] = div_step(first, 3'(QuotW - 1 - s));
    end else begin : g_body
      assign st_next[s] = div_step(st[s-1], 3'(QuotW - 1 - s));
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv[s]) begin
        v[s] <= (s == 0) ? q_valid : v[(s == 0) ? 0 : s-1];
      end
      if (adv[s]) begin
        st[s] <= st_next[s];
      end
    end
  end

  assign q_stall         = !adv[0];
  assign out_valid       = v[QuotW-1];
  assign hue             = st[QuotW-1].it.zero_hue ? '0 : st[QuotW-1].q_h;
  assign saturation      = st[QuotW-1].it.black ? '0 : st[QuotW-1].q_s;
  assign intensity_value = st[QuotW-1].it.val;

endmodule

>>> hdl/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Converts 8-bit RGB pixels to 8-bit hue, saturation and value.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock when nothing stalls and returns one HSV
// item for every pixel, in order. A pixel passes through the front register,
// the queue, and the divider pipeline of the back, which produces one quotient
// bit per stage for both the saturation and the hue division. Value is the
// largest channel, saturation is floor((max-min)*255/max), and hue is
// floor(255*(k*d +/- n)/(6*d)) for the sextant offset k. A black pixel gives
// all zeros and a grey pixel gives hue zero. Pure red and any pixel with red
// largest and green equal to blue report hue 255, one full turn. The queue
// between front and back lets the front keep accepting items while the output
// is stalled, until it fills.
module rgb_to_hsv_converter_core #(
  parameter int unsigned QueueDepth = rhc_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] hue,
  output logic [7:0] saturation,
  output logic [7:0] intensity_value
);
  import rhc_pkg::*;

  logic      f_valid, f_stall, b_valid, b_stall;
  rhc_item_t f_item, b_item;

  // Front: classify the pixel and form numerators and divisors.
  rhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .q_valid  (f_valid),
    .q_stall  (f_stall),
    .q_item   (f_item)
  );

  // Queue: decouples the front from stalls in the back.
  rhc_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_stall (b_stall),
    .rd_item  (b_item)
  );

  // Back: pipelined divisions and the black and grey overrides.
  rhc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (b_valid),
    .q_stall         (b_stall),
    .q_item          (b_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hue             (hue),
    .saturation      (saturation),
    .intensity_value (intensity_value)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives pixels through the core under several idle and stall patterns and
// checks every HSV item against an integer model of the conversion.
// ----------------------------------------------------------------------------

// Holds the HSV items still owed by the core, in pixel order.
class hsv_scoreboard;
  logic [23:0] owed_hsv[$];
  int unsigned mismatches;

  // Integer form of the conversion: sextant pick, then two floor divisions.
  function automatic logic [23:0] convert_pixel(logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b);
    int unsigned mx, mn, k, n, d, num, h, s;
    bit add;
    if (g > b) begin
      if (r > g) begin
        mx = r; mn = b; k = 1; add = 0; n = r - g;
      end else if (b > r) begin
        mx = g; mn = r; k = 3; add = 0; n = g - b;
      end else begin
        mx = g; mn = b; k = 1; add = 1; n = g - r;
      end
    end else begin
      if (r > b) begin
        mx = r; mn = g; k = 5; add = 1; n = r - b;
      end else if (g > r) begin
        mx = b; mn = r; k = 3; add = 1; n = b - g;
      end else begin
        mx = b; mn = g; k = 5; add = 0; n = b - r;
      end
    end
    if (mx == 0) return 24'h0;
    d = mx - mn;
    s = (d * 255) / mx;
    if (d == 0) begin
      h = 0;
    end else begin
      num = add ? (k * d + n) : (k * d - n);
      h = (num * 255) / (6 * d);
    end
    return {h[7:0], s[7:0], mx[7:0]};
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    owed_hsv.push_back(convert_pixel(r, g, b));
  endfunction

  function void check_hsv(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    logic [23:0] exp_hsv;
    if (owed_hsv.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected item h=%0d s=%0d v=%0d", h, s, v);
      return;
    end
    exp_hsv = owed_hsv.pop_front();
    if (exp_hsv !== {h, s, v}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                 exp_hsv[23:16], exp_hsv[15:8], exp_hsv[7:0], h, s, v);
    end
  endfunction
endclass

module testbench;
  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] intensity_value;

  hsv_scoreboard board;
  // Percent chances of a sender gap and of a receiver stall in this phase.
  int unsigned gap_pct;
  int unsigned stall_pct;
  // High while the receiver is held off for a long stretch.
  bit          hold_on;
  event        hold_start;

  rgb_to_hsv_converter_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .hue(hue), .saturation(saturation), .intensity_value(intensity_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Long receiver hold-off, counted in cycles once it is requested.
  initial begin
    @(hold_start);
    hold_on <= 1'b1;
    repeat (60) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver: stalls at random, or holds off for a long stretch on request.
  // Checking happens on the edge where the item is actually taken.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_hsv(hue, saturation, intensity_value);
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one pixel and waits until the core takes it. Valid stays high
  // between back-to-back items, so it gets a single assignment per edge.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(r, g, b);
  endtask

  // Random pixel biased toward ties, extremes and greys, which steer sextants.
  task automatic send_random_pixel();
    logic [7:0] c[3];
    int unsigned kind;
    kind = $urandom_range(9);
    foreach (c[i]) c[i] = 8'($urandom_range(255));
    case (kind)
      0: begin
        c[1] = c[0]; c[2] = c[0];
      end
      1: c[$urandom_range(2)] = c[$urandom_range(2)];
      2: c[$urandom_range(2)] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
      3: foreach (c[i]) c[i] = 8'($urandom_range(3));
      default: ;
    endcase
    send_pixel(c[0], c[1], c[2]);
  endtask

  task automatic run_phase(int unsigned gp, int unsigned sp, int unsigned count);
    gap_pct   = gp;
    stall_pct = sp;
    repeat (count) send_random_pixel();
  endtask

  initial begin
    board      = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    red        = 8'h00;
    green      = 8'h00;
    blue       = 8'h00;
    gap_pct    = 0;
    stall_pct  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: black, white, greys, primaries, secondaries, and every
    // sextant including the tie cases. Pure red and red-max with green equal
    // to blue give the full-turn hue.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hc8, 8'h40, 8'h40);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'hc8, 8'h64, 8'h10);
    send_pixel(8'h64, 8'hc8, 8'h10);
    send_pixel(8'h10, 8'hc8, 8'h64);
    send_pixel(8'h10, 8'h64, 8'hc8);
    send_pixel(8'h64, 8'h10, 8'hc8);
    send_pixel(8'hc8, 8'h10, 8'h64);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'haa, 8'h55, 8'h55);
    send_pixel(8'hfe, 8'hff, 8'h01);

    // Random phases with each idling pattern.
    run_phase(0, 0, 150);
    run_phase(47, 0, 120);
    run_phase(0, 47, 120);
    run_phase(17, 17, 120);

    // Long receiver hold-off while pixels keep coming, so the queue fills
    // and the core pushes back on its input.
    -> hold_start;
    run_phase(0, 0, 80);
    run_phase(0, 0, 40);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (board.owed_hsv.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.mismatches == 0 && board.owed_hsv.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
